// ===== sv/frb_pkg.sv =====
// Package for the formant resonator biquad: widths, defaults and register map.
// No dependencies; used by the interfaces, the top level and the checker.
package frb_pkg;

  // Default data widths
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int COEFF_FRAC_BITS_DEF = 16;
  // Integer bits of the Q4.F coefficient format
  localparam int COEFF_INT_BITS      = 4;

  // Configuration port
  localparam int APB_DATA_BITS = 32;
  localparam int ADDR_BITS     = 5;
  localparam int REG_IDX_BITS  = 3;

  // Samples at the head of a block that give zero
  localparam logic [1:0] WARMUP = 2'd3;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_FF_NOW      = 3'd0,
    REG_FF_ONE_BACK = 3'd1,
    REG_FF_TWO_BACK = 3'd2,
    REG_FB_ONE_BACK = 3'd3,
    REG_FB_TWO_BACK = 3'd4
  } reg_idx_t;

endpackage

// ===== sv/frb_in_if.sv =====
// Input request channel of the resonator: valid/ready with one sample.
// Depends on frb_pkg for the default sample width.
interface frb_in_if #(
  parameter int SAMPLE_BITS = frb_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          block_start;

  modport source (output valid, output sample_in, output block_start, input ready);
  modport sink   (input valid, input sample_in, input block_start, output ready);
endinterface

// ===== sv/frb_out_if.sv =====
// Result request channel of the resonator: valid/ready with one sample.
// Depends on frb_pkg for the default sample width.
interface frb_out_if #(
  parameter int SAMPLE_BITS = frb_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// ===== sv/formant_resonator_biquad.sv =====
// Path: an accepted request is held in the input register; its result goes to the result
// register, and the five products and their sum sit between the two registers.
// Throughput: one request per cycle unless dout.ready holds back the result, with the
// history updated as each result is registered.
// Reset (rst, synchronous): empties both registers, clears the sample history and the
// block position, and loads the coefficients with unity gain on the current input.
module formant_resonator_biquad #(
  parameter int SAMPLE_BITS     = frb_pkg::SAMPLE_BITS_DEF,
  parameter int COEFF_FRAC_BITS = frb_pkg::COEFF_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  frb_in_if.sink                             din,
  frb_out_if.source                          dout,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [frb_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [frb_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [frb_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready
);
  import frb_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int F  = COEFF_FRAC_BITS;
  localparam int CW = COEFF_FRAC_BITS + COEFF_INT_BITS;
  localparam int MW = S + CW;           // one product
  localparam int PW = MW + 3;           // sum of five products
  localparam int QW = PW - F;           // sum after dropping the fraction

  localparam logic signed [CW-1:0] COEFF_ONE  = CW'(1) << F;
  localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) << (F - 1);
  localparam logic signed [S-1:0]  SAMPLE_MAX = {1'b0, {(S-1){1'b1}}};
  localparam logic signed [S-1:0]  SAMPLE_MIN = {1'b1, {(S-1){1'b0}}};

  // Coefficient registers
  logic signed [CW-1:0] ff_now, ff_one_back, ff_two_back, fb_one_back, fb_two_back;

  // Input register
  logic                 in_full;
  logic signed [S-1:0]  x_reg;
  logic                 bs_reg;

  // Filter history
  logic signed [S-1:0]  input_one_back, input_two_back;
  logic signed [S-1:0]  output_one_back, output_two_back;
  logic [1:0]           block_position;

  // Result register
  logic                 out_valid;
  logic signed [S-1:0]  out_sample;
  logic                 out_clip;

  // Datapath
  logic                 out_take, advance;
  logic [1:0]           pos_eff;
  logic                 warm;
  logic signed [MW-1:0] p0, p1, p2, p3, p4;
  logic signed [PW-1:0] sum;
  logic signed [QW-1:0] q;
  logic                 fits;
  logic signed [S-1:0]  y_next;
  logic                 clip_next;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;

  // ---------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[REG_IDX_BITS+1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      ff_now      <= COEFF_ONE;
      ff_one_back <= '0;
      ff_two_back <= '0;
      fb_one_back <= '0;
      fb_two_back <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FF_NOW:      ff_now      <= pwdata[CW-1:0];
        REG_FF_ONE_BACK: ff_one_back <= pwdata[CW-1:0];
        REG_FF_TWO_BACK: ff_two_back <= pwdata[CW-1:0];
        REG_FB_ONE_BACK: fb_one_back <= pwdata[CW-1:0];
        REG_FB_TWO_BACK: fb_two_back <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Read back, sign extended to the bus
  always_comb begin
    unique case (cfg_idx)
      REG_FF_NOW:      prdata = APB_DATA_BITS'(ff_now);
      REG_FF_ONE_BACK: prdata = APB_DATA_BITS'(ff_one_back);
      REG_FF_TWO_BACK: prdata = APB_DATA_BITS'(ff_two_back);
      REG_FB_ONE_BACK: prdata = APB_DATA_BITS'(fb_one_back);
      REG_FB_TWO_BACK: prdata = APB_DATA_BITS'(fb_two_back);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Handshake: the result register frees up when empty or taken
  // ---------------------------------------------------------------
  assign out_take  = !out_valid || dout.ready;
  assign advance   = in_full && out_take;
  assign din.ready = !in_full || out_take;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= (din.valid && din.ready) || (in_full && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      x_reg  <= din.sample_in;
      bs_reg <= din.block_start;
    end
  end

  // ---------------------------------------------------------------
  // Filter arithmetic
  // ---------------------------------------------------------------
  assign pos_eff = bs_reg ? 2'd0 : block_position;
  assign warm    = (pos_eff < WARMUP);

  assign p0 = ff_now      * x_reg;
  assign p1 = ff_one_back * input_one_back;
  assign p2 = ff_two_back * input_two_back;
  assign p3 = fb_one_back * output_one_back;
  assign p4 = fb_two_back * output_two_back;

  // Exact sum plus half an LSB, then floor by dropping the fraction
  assign sum  = PW'(p0) + PW'(p1) + PW'(p2) + PW'(p3) + PW'(p4) + ROUND_HALF;
  assign q    = sum[PW-1:F];
  assign fits = (q[QW-1:S-1] == '0) || (q[QW-1:S-1] == '1);

  // Warm-up gives zero; otherwise saturate to the sample range
  always_comb begin
    if (warm) begin
      y_next    = '0;
      clip_next = 1'b0;
    end else if (fits) begin
      y_next    = q[S-1:0];
      clip_next = 1'b0;
    end else begin
      y_next    = q[QW-1] ? SAMPLE_MIN : SAMPLE_MAX;
      clip_next = 1'b1;
    end
  end

  // History and block position
  always_ff @(posedge clk) begin
    if (rst) begin
      input_one_back  <= '0;
      input_two_back  <= '0;
      output_one_back <= '0;
      output_two_back <= '0;
      block_position  <= '0;
    end else if (advance) begin
      input_two_back  <= input_one_back;
      input_one_back  <= x_reg;
      output_two_back <= output_one_back;
      output_one_back <= y_next;
      block_position  <= warm ? pos_eff + 2'd1 : pos_eff;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sample <= y_next;
      out_clip   <= clip_next;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.sample_out = out_sample;
  assign dout.clipped    = out_clip;

endmodule

// ===== sv/frb_checker.sv =====
// Port-level checks for the resonator, bound to the top level.
// Depends on frb_pkg and on the ports of formant_resonator_biquad.
module frb_port_checker #(
  parameter int SAMPLE_BITS = frb_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] sample_out,
  input logic                          clipped
);
  import frb_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Nothing comes out right after reset
  a_idle_after_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // A free result slot always lets a new request in
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while result slot free");

  // A clipped result sits at one of the limits
  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |-> (sample_out == SMAX || sample_out == SMIN))
    else $error("clipped result not at a limit");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample_out) && $stable(clipped)))
    else $error("stalled result changed");

endmodule

bind formant_resonator_biquad frb_port_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_frb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (din.ready),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .sample_out (dout.sample_out),
  .clipped    (dout.clipped)
);
